@@ rtl/tvp_pkg.sv @@
`timescale 1ns / 1ps

package tvp_pkg;

    localparam int POS_W      = 32;
    localparam int SPEED_W    = 31;
    localparam int TICK_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ERR_W      = POS_W + 1;
    localparam int PROD_W     = SPEED_W + ERR_W;
    localparam int SQ_W       = 2 * SPEED_W;
    localparam int CMD_W      = POS_W + 2;

    typedef enum logic [1:0] {
        PH_STOP   = 2'd0,
        PH_CRUISE = 2'd1,
        PH_ACCEL  = 2'd2,
        PH_DECEL  = 2'd3
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_SPEED     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_ACCEL     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITS_ENABLED    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_UPPER    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LOWER    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_SPEED_LIMIT = CFG_IDX_W'(5);

    localparam logic [SPEED_W-1:0]      RST_PROFILE_SPEED     = SPEED_W'(65536);
    localparam logic [SPEED_W-1:0]      RST_PROFILE_ACCEL     = SPEED_W'(65536);
    localparam logic signed [POS_W-1:0] RST_POSITION_UPPER    = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] RST_POSITION_LOWER    = 32'sh8000_0000;
    localparam logic [SPEED_W-1:0]      RST_JOINT_SPEED_LIMIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [SPEED_W-1:0]      profile_speed;
        logic [SPEED_W-1:0]      profile_accel;
        logic                    limits_enabled;
        logic signed [POS_W-1:0] position_upper;
        logic signed [POS_W-1:0] position_lower;
        logic [SPEED_W-1:0]      joint_speed_limit;
    } t_cfg;

    // Everything about one tick that does not depend on the stored velocity.
    typedef struct packed {
        logic              err_neg;
        logic              stop;
        logic [PROD_W-1:0] accel_err;
        logic [POS_W-1:0]  dv;
    } t_front;

endpackage

@@ rtl/tvp_ifs.sv @@
`timescale 1ns / 1ps

interface tvp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tvp_pkg::POS_W-1:0]     target_position;
    logic signed [tvp_pkg::POS_W-1:0]     measured_position;
    logic        [tvp_pkg::TICK_W-1:0]    tick_length;

    modport source (output valid, target_position, measured_position, tick_length,
                    input ready);
    modport sink   (input valid, target_position, measured_position, tick_length,
                    output ready);
endinterface

interface tvp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tvp_pkg::POS_W-1:0]     velocity_out;
    logic        [1:0]                    motion_phase;

    modport source (output valid, velocity_out, motion_phase, input ready);
    modport sink   (input valid, velocity_out, motion_phase, output ready);
endinterface

interface tvp_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tvp_pkg::CFG_IDX_W-1:0]        index;
    logic [tvp_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tvp_front.sv @@
`timescale 1ns / 1ps

module tvp_front #(
    parameter int FRACTION_BITS = 16
) (
    input  tvp_pkg::t_cfg                     i_cfg,
    input  logic signed [tvp_pkg::POS_W-1:0]  i_target_position,
    input  logic signed [tvp_pkg::POS_W-1:0]  i_measured_position,
    input  logic        [tvp_pkg::TICK_W-1:0] i_tick_length,
    output tvp_pkg::t_front                   o_front
);
    import tvp_pkg::*;

    // 0.0001 rounded to the nearest fixed-point step.
    localparam int STOP_THRESHOLD = ((1 << FRACTION_BITS) + 5000) / 10000;
    localparam int DV_FULL_W      = SPEED_W + TICK_W;

    logic signed [POS_W-1:0] w_target;
    logic signed [ERR_W-1:0] w_err;
    logic [ERR_W-1:0]        w_abs_err;
    logic [DV_FULL_W-1:0]    w_dv_prod;
    logic [DV_FULL_W-1:0]    w_dv;

    always_comb begin
        w_target = i_target_position;
        if (i_cfg.limits_enabled) begin
            if (i_target_position > i_cfg.position_upper) begin
                w_target = i_cfg.position_upper;
            end else if (i_target_position < i_cfg.position_lower) begin
                w_target = i_cfg.position_lower;
            end
        end

        w_err     = ERR_W'(w_target) - ERR_W'(i_measured_position);
        w_abs_err = w_err[ERR_W-1] ? ERR_W'(-w_err) : ERR_W'(w_err);

        w_dv_prod = DV_FULL_W'(i_cfg.profile_accel) * DV_FULL_W'(i_tick_length);
        w_dv      = w_dv_prod >> FRACTION_BITS;

        o_front.err_neg   = w_err[ERR_W-1];
        o_front.stop      = (w_abs_err <= ERR_W'(STOP_THRESHOLD));
        o_front.accel_err = PROD_W'(i_cfg.profile_accel) * PROD_W'(w_abs_err);
        // A step of 2^32 or more always ends at the speed clamp, so saturate it.
        o_front.dv        = (|w_dv[DV_FULL_W-1:POS_W]) ? '1 : w_dv[POS_W-1:0];
    end

endmodule

@@ rtl/trapezoidal_velocity_profile_step_core.sv @@
`timescale 1ns / 1ps

// Trapezoidal velocity profile, one control tick per beat.
// i_in carries target position, measured position and tick length; o_out
// returns the signed velocity command and the motion phase (stop, cruise,
// accelerate, decelerate). i_cfg writes the six profile registers by index;
// it is always ready and should only be used while no tick is in flight.
// A beat is registered in the first stage, then in the output register.
// Throughput is one beat per cycle: the first stage takes the clamp, the
// position error and the two products that do not need the stored speed;
// the second stage squares the stored speed, picks the phase, updates and
// clamps the speed, and writes it back, which bounds the clock period.
// The pipeline advances as a whole: while o_out is valid and not taken,
// i_in.ready is low and both stages hold their contents.
// Reset clears the stored speed to zero, empties both stages and loads the
// register defaults.
module trapezoidal_velocity_profile_step_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvp_cfg_if.sink    i_cfg,
    tvp_in_if.sink     i_in,
    tvp_out_if.source  o_out
);
    import tvp_pkg::*;

    t_cfg                    r_cfg;
    t_front                  w_front;
    t_front                  r_s1;
    logic                    r_s1_valid;
    logic signed [POS_W-1:0] r_prev_speed;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_velocity_out;
    t_phase                  r_motion_phase;

    logic                    w_adv;
    logic signed [POS_W-1:0] w_neg_prev;
    logic [SPEED_W-1:0]      w_abs_v;
    logic [SQ_W-1:0]         w_vsq;
    logic [SQ_W-1:0]         w_half_vsq;
    t_phase                  n_phase;
    logic signed [CMD_W-1:0] w_cmd;
    logic signed [CMD_W-1:0] w_lim;
    logic signed [POS_W-1:0] n_speed;
    logic signed [POS_W-1:0] n_velocity_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.profile_speed     <= RST_PROFILE_SPEED;
            r_cfg.profile_accel     <= RST_PROFILE_ACCEL;
            r_cfg.limits_enabled    <= 1'b0;
            r_cfg.position_upper    <= RST_POSITION_UPPER;
            r_cfg.position_lower    <= RST_POSITION_LOWER;
            r_cfg.joint_speed_limit <= RST_JOINT_SPEED_LIMIT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_PROFILE_SPEED:     r_cfg.profile_speed     <= i_cfg.data[SPEED_W-1:0];
                CFG_PROFILE_ACCEL:     r_cfg.profile_accel     <= i_cfg.data[SPEED_W-1:0];
                CFG_LIMITS_ENABLED:    r_cfg.limits_enabled    <= i_cfg.data[0];
                CFG_POSITION_UPPER:    r_cfg.position_upper    <= $signed(i_cfg.data);
                CFG_POSITION_LOWER:    r_cfg.position_lower    <= $signed(i_cfg.data);
                CFG_JOINT_SPEED_LIMIT: r_cfg.joint_speed_limit <= i_cfg.data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    tvp_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_cfg               (r_cfg),
        .i_target_position   (i_in.target_position),
        .i_measured_position (i_in.measured_position),
        .i_tick_length       (i_in.tick_length),
        .o_front             (w_front)
    );

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Second stage: phase decision and speed update against the stored speed.
    always_comb begin
        w_neg_prev = -r_prev_speed;
        w_abs_v    = r_prev_speed[POS_W-1] ? w_neg_prev[SPEED_W-1:0]
                                           : r_prev_speed[SPEED_W-1:0];
        w_vsq      = SQ_W'(w_abs_v) * SQ_W'(w_abs_v);
        // a|e| < ceil(v^2/2) is the same test as 2a|e| < v^2.
        w_half_vsq = SQ_W'(({1'b0, w_vsq} + (SQ_W + 1)'(1)) >> 1);

        if (r_s1.stop) begin
            n_phase = PH_STOP;
        end else if (r_s1.accel_err < PROD_W'(w_half_vsq)) begin
            n_phase = PH_DECEL;
        end else if (r_prev_speed < $signed({1'b0, r_cfg.profile_speed})) begin
            n_phase = PH_ACCEL;
        end else begin
            n_phase = PH_CRUISE;
        end

        case (n_phase)
            PH_CRUISE: w_cmd = CMD_W'($signed({1'b0, r_cfg.profile_speed}));
            PH_ACCEL:  w_cmd = CMD_W'(r_prev_speed) + $signed({2'b00, r_s1.dv});
            PH_DECEL:  w_cmd = CMD_W'(r_prev_speed) - $signed({2'b00, r_s1.dv});
            default:   w_cmd = '0;
        endcase

        w_lim = $signed({3'b000, r_cfg.joint_speed_limit});
        if (w_cmd > w_lim) begin
            n_speed = $signed({1'b0, r_cfg.joint_speed_limit});
        end else if (w_cmd < -w_lim) begin
            n_speed = -$signed({1'b0, r_cfg.joint_speed_limit});
        end else begin
            n_speed = w_cmd[POS_W-1:0];
        end

        n_velocity_out = r_s1.err_neg ? -n_speed : n_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_speed <= '0;
        end else if (w_adv) begin
            r_s1_valid  <= i_in.valid;
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_prev_speed <= n_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (i_in.valid) begin
                r_s1 <= w_front;
            end
            if (r_s1_valid) begin
                r_velocity_out <= n_velocity_out;
                r_motion_phase <= n_phase;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.velocity_out = r_velocity_out;
    assign o_out.motion_phase = r_motion_phase;

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_motion_phase == PH_STOP) |-> (r_velocity_out == '0))
        else $error("stop phase with nonzero velocity");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_velocity_out == r_prev_speed || r_velocity_out == w_neg_prev))
        else $error("output velocity does not match stored speed");

    a_speed_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_prev_speed)) |-> $past(w_adv && r_s1_valid))
        else $error("stored speed changed without a beat leaving the first stage");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("output beat appeared without a first-stage beat");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tvp_pkg::*;

    localparam int FRACTION_BITS = 16;
    localparam longint STOP_THRESHOLD = ((64'sd1 <<< FRACTION_BITS) + 5000) / 10000;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_TICKS = 500;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);

    typedef struct packed {
        logic signed [POS_W-1:0] vel;
        t_phase                  ph;
    } t_vel_cmd;

    typedef struct {
        bit                      is_reg;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [POS_W-1:0] tgt;
        logic signed [POS_W-1:0] meas;
        logic [TICK_W-1:0]       tick;
        bit                      known;
        logic signed [POS_W-1:0] vel;
        t_phase                  ph;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    tvp_cfg_if cfg_bus();
    tvp_in_if  in_bus();
    tvp_out_if out_bus();

    trapezoidal_velocity_profile_step_core #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Shadow copy of the profile registers and the stored speed.
    longint m_speed;
    longint m_accel;
    bit     m_limits;
    longint m_upper;
    longint m_lower;
    longint m_speed_limit;
    longint stored_speed;

    t_vel_cmd    pending_cmds[$];
    t_script_row script[$];

    int  mismatches;
    int  ticks_sent;
    int  directed_ticks;
    int  reg_writes;
    int  phase_hits[4];
    int  idle_cycles;
    bit  steady;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [POS_W-1:0] sat32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PROFILE_SPEED:     m_speed = data[SPEED_W-1:0];
            CFG_PROFILE_ACCEL:     m_accel = data[SPEED_W-1:0];
            CFG_LIMITS_ENABLED:    m_limits = data[0];
            CFG_POSITION_UPPER:    m_upper = signed'(data);
            CFG_POSITION_LOWER:    m_lower = signed'(data);
            CFG_JOINT_SPEED_LIMIT: m_speed_limit = data[SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    // One control tick: clamp the target, pick the phase, update the stored speed.
    function automatic void profile_tick(input logic signed [POS_W-1:0] tgt,
                                         input logic signed [POS_W-1:0] meas,
                                         input logic [TICK_W-1:0] tick,
                                         output logic signed [POS_W-1:0] vel,
                                         output t_phase ph);
        longint t, e, v, cmd;
        longint unsigned abs_e, abs_v, v_sq, accel_e, dv;
        t = tgt;
        if (m_limits) begin
            if (t > m_upper) t = m_upper;
            else if (t < m_lower) t = m_lower;
        end
        e = t - longint'(meas);
        abs_e = (e < 0) ? longint'(-e) : e;
        v = stored_speed;
        abs_v = (v < 0) ? longint'(-v) : v;
        v_sq = abs_v * abs_v;
        accel_e = longint'(m_accel) * abs_e;
        // 2a|e| < v^2 is tested as a|e| < ceil(v^2 / 2).
        if (abs_e <= STOP_THRESHOLD) ph = PH_STOP;
        else if (accel_e < (v_sq + 1) / 2) ph = PH_DECEL;
        else if (v < m_speed) ph = PH_ACCEL;
        else ph = PH_CRUISE;
        dv = (longint'(m_accel) * longint'(tick)) >> FRACTION_BITS;
        case (ph)
            PH_CRUISE: cmd = m_speed;
            PH_ACCEL:  cmd = v + longint'(dv);
            PH_DECEL:  cmd = v - longint'(dv);
            default:   cmd = 0;
        endcase
        if (cmd > m_speed_limit) cmd = m_speed_limit;
        else if (cmd < -m_speed_limit) cmd = -m_speed_limit;
        stored_speed = cmd;
        if (e < 0) cmd = -cmd;
        vel = cmd[31:0];
        phase_hits[ph]++;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 15) return '1;
        if (r < 25) return TICK_W'($urandom());
        return TICK_W'($urandom_range(32'h100, 32'h2000));
    endfunction

    // Rate-like register word; bit 31 carries junk that the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_rate();
        logic [CFG_DATA_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = 32'd0;
            1:       w = 32'd1;
            2:       w = 32'h7FFF_FFFF;
            3:       w = $urandom();
            default: w = $urandom_range(32'h1000, 32'h40_0000);
        endcase
        w[31] = $urandom_range(0, 1);
        return w;
    endfunction

    function automatic t_script_row tick_row(input logic signed [POS_W-1:0] tgt,
                                             input logic signed [POS_W-1:0] meas,
                                             input logic [TICK_W-1:0] tick);
        t_script_row r;
        r.is_reg = 1'b0;
        r.idx = CFG_PROFILE_SPEED;
        r.data = '0;
        r.tgt = tgt;
        r.meas = meas;
        r.tick = tick;
        r.known = 1'b0;
        r.vel = '0;
        r.ph = PH_STOP;
        return r;
    endfunction

    function automatic t_script_row known_row(input logic signed [POS_W-1:0] tgt,
                                              input logic signed [POS_W-1:0] meas,
                                              input logic [TICK_W-1:0] tick,
                                              input logic signed [POS_W-1:0] vel,
                                              input t_phase ph);
        t_script_row r;
        r = tick_row(tgt, meas, tick);
        r.known = 1'b1;
        r.vel = vel;
        r.ph = ph;
        return r;
    endfunction

    function automatic t_script_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        t_script_row r;
        r = tick_row('0, '0, '0);
        r.is_reg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    task automatic send_tick(input logic signed [POS_W-1:0] tgt,
                             input logic signed [POS_W-1:0] meas,
                             input logic [TICK_W-1:0] tick,
                             input bit known,
                             input logic signed [POS_W-1:0] known_vel,
                             input t_phase known_ph,
                             output logic signed [POS_W-1:0] vel);
        logic signed [POS_W-1:0] v;
        t_phase p;
        t_vel_cmd c;
        int gap;
        @(negedge i_clk);
        in_bus.valid <= 1'b1;
        in_bus.target_position <= tgt;
        in_bus.measured_position <= meas;
        in_bus.tick_length <= tick;
        do @(posedge i_clk); while (!in_bus.ready);
        profile_tick(tgt, meas, tick, v, p);
        c.vel = known ? known_vel : v;
        c.ph = known ? known_ph : p;
        pending_cmds.push_back(c);
        vel = v;
        ticks_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every outstanding beat has come back.
    task automatic settle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        load_reg(idx, data);
        reg_writes++;
        if (last) begin
            @(negedge i_clk);
            cfg_bus.valid <= 1'b0;
        end
    endtask

    initial begin
        int n;
        out_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = pick_gap();
            @(negedge i_clk);
            out_bus.ready <= (n == 0);
            if (n > 0) repeat (n - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_vel_cmd c;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_cmds.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected beat: vel=%0d phase=%0d", $realtime,
                             out_bus.velocity_out, out_bus.motion_phase);
                mismatches++;
            end else begin
                c = pending_cmds.pop_front();
                if (out_bus.velocity_out !== c.vel || out_bus.motion_phase !== c.ph) begin
                    if (mismatches < 10)
                        $display("[%0t] mismatch: vel exp %0d got %0d, phase exp %0d got %0d",
                                 $realtime, c.vel, out_bus.velocity_out, c.ph,
                                 out_bus.motion_phase);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_cmds.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit last;
        int kind, burst, rand_ticks;
        logic signed [POS_W-1:0] pv, tgt, meas, trk_pos, trk_target;
        logic [TICK_W-1:0] tick;
        logic [CFG_DATA_W-1:0] up_w, lo_w;

        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.target_position = '0;
        in_bus.measured_position = '0;
        in_bus.tick_length = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        steady = 1'b0;
        mismatches = 0;
        ticks_sent = 0;
        reg_writes = 0;
        idle_cycles = 0;
        m_speed = RST_PROFILE_SPEED;
        m_accel = RST_PROFILE_ACCEL;
        m_limits = 1'b0;
        m_upper = RST_POSITION_UPPER;
        m_lower = RST_POSITION_LOWER;
        m_speed_limit = RST_JOINT_SPEED_LIMIT;
        stored_speed = 0;

        // Reset defaults, threshold edge, widest error both ways, sign of the error.
        script.push_back(known_row(0, 0, 20'h0, 0, PH_STOP));
        script.push_back(known_row(7, 0, 20'hFFFFF, 0, PH_STOP));
        script.push_back(known_row(8, 0, 20'h10000, 65536, PH_ACCEL));
        script.push_back(known_row(32'sh7FFF_FFFF, 32'sh8000_0000, 20'hFFFFF, 65536, PH_CRUISE));
        script.push_back(known_row(32'sh8000_0000, 32'sh7FFF_FFFF, 20'hFFFFF, -65536, PH_CRUISE));
        script.push_back(known_row(100, 0, 20'h10000, 0, PH_DECEL));
        script.push_back(known_row(0, 8, 20'h08000, -32768, PH_ACCEL));
        // Largest rates: the speed step saturates at the joint limit.
        script.push_back(reg_row(CFG_PROFILE_SPEED, 32'hFFFF_FFFF));
        script.push_back(reg_row(CFG_PROFILE_ACCEL, 32'h7FFF_FFFF));
        script.push_back(known_row(1000, 0, 20'hFFFFF, 32'sh7FFF_FFFF, PH_ACCEL));
        script.push_back(known_row(0, 1000, 20'h0, 32'sh8000_0001, PH_DECEL));
        // Zero acceleration decelerates exactly when the stored speed is nonzero.
        script.push_back(reg_row(CFG_PROFILE_ACCEL, 32'h8000_0000));
        script.push_back(known_row(1000000, 0, 20'h12345, 32'sh7FFF_FFFF, PH_DECEL));
        script.push_back(known_row(12345, 12345, 20'h12345, 0, PH_STOP));
        script.push_back(known_row(1000000, 0, 20'h12345, 0, PH_ACCEL));
        // Tight joint limit; deceleration drives the stored speed negative.
        script.push_back(reg_row(CFG_PROFILE_ACCEL, 32'h0001_0000));
        script.push_back(reg_row(CFG_JOINT_SPEED_LIMIT, 32'h0004_0000));
        script.push_back(known_row(32'sh0010_0000, 0, 20'hFFFFF, 262144, PH_ACCEL));
        script.push_back(tick_row(100, 0, 20'hFFFFF));
        script.push_back(tick_row(0, 100, 20'h00100));
        script.push_back(tick_row(32'sh1000_0000, 0, 20'h01000));
        script.push_back(tick_row(-5, -5, 20'h01000));
        // Position clamp, then crossed limits where the upper test wins.
        script.push_back(reg_row(CFG_LIMITS_ENABLED, 32'hFFFF_FFFF));
        script.push_back(reg_row(CFG_POSITION_UPPER, 32'd1000));
        script.push_back(reg_row(CFG_POSITION_LOWER, -32'sd1000));
        script.push_back(reg_row(CFG_JOINT_SPEED_LIMIT, 32'hFFFF_FFFF));
        script.push_back(reg_row(CFG_PROFILE_SPEED, 32'd65536));
        script.push_back(tick_row(32'sh7FFF_FFFF, 0, 20'h04000));
        script.push_back(tick_row(32'sh8000_0000, 0, 20'h04000));
        script.push_back(reg_row(CFG_POSITION_UPPER, -32'sd1000));
        script.push_back(reg_row(CFG_POSITION_LOWER, 32'd1000));
        script.push_back(tick_row(0, 0, 20'h04000));
        script.push_back(tick_row(-5000, 0, 20'h04000));
        // Writes past the last register must change nothing; zero speed and limit.
        script.push_back(reg_row(CFG_SPARE_LO, 32'h0));
        script.push_back(reg_row(CFG_SPARE_HI, 32'hFFFF_FFFF));
        script.push_back(reg_row(CFG_JOINT_SPEED_LIMIT, 32'h0));
        script.push_back(reg_row(CFG_PROFILE_SPEED, 32'h0));
        script.push_back(tick_row(32'sh0010_0000, 0, 20'h10000));
        script.push_back(tick_row(32'sh8000_0000, 32'sh7FFF_FFFF, 20'h10000));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < script.size(); i++) begin
            if (script[i].is_reg) begin
                if (i == 0 || !script[i-1].is_reg) settle();
                last = (i + 1 == script.size()) || !script[i+1].is_reg;
                write_reg(script[i].idx, script[i].data, last);
            end else begin
                send_tick(script[i].tgt, script[i].meas, script[i].tick, script[i].known,
                          script[i].vel, script[i].ph, pv);
            end
        end
        directed_ticks = ticks_sent;

        // Random part: each phase loads a fresh register set, then mostly drives a
        // closed loop where the measured position follows the commanded velocity.
        rand_ticks = 0;
        while (rand_ticks < RANDOM_TICKS) begin
            settle();
            steady = ($urandom_range(0, 4) == 0);
            trk_pos = signed'($urandom()) >>> $urandom_range(0, 12);
            trk_target = sat32(longint'(trk_pos)
                               + longint'(signed'($urandom()) >>> $urandom_range(10, 26)));
            case ($urandom_range(0, 9))
                0: begin
                    up_w = 32'h7FFF_FFFF;
                    lo_w = 32'h8000_0000;
                end
                1, 2: begin
                    up_w = $urandom();
                    lo_w = $urandom();
                end
                default: begin
                    up_w = sat32(longint'(trk_target) + $urandom_range(0, 32'h10_0000)
                                 - 32'sh8_0000);
                    lo_w = sat32(longint'(trk_pos) - $urandom_range(0, 32'h10_0000));
                end
            endcase
            write_reg(CFG_PROFILE_SPEED, pick_rate(), 1'b0);
            write_reg(CFG_PROFILE_ACCEL, pick_rate(), 1'b0);
            write_reg(CFG_LIMITS_ENABLED, $urandom(), 1'b0);
            write_reg(CFG_POSITION_UPPER, up_w, 1'b0);
            write_reg(CFG_POSITION_LOWER, lo_w, 1'b0);
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom(), 1'b0);
            write_reg(CFG_JOINT_SPEED_LIMIT, pick_rate(), 1'b1);

            burst = $urandom_range(8, 40);
            repeat (burst) begin
                kind = $urandom_range(0, 99);
                if (kind < 4)
                    trk_target = sat32(longint'(trk_pos)
                                       + longint'(signed'($urandom()) >>> $urandom_range(10, 26)));
                if (kind < 70) begin
                    tgt = trk_target;
                    meas = trk_pos;
                end else if (kind < 85) begin
                    // Errors straddling the stop threshold.
                    tgt = sat32(longint'(trk_pos) + $urandom_range(0, 24) - 12);
                    meas = trk_pos;
                end else begin
                    tgt = $urandom();
                    meas = $urandom();
                end
                tick = pick_tick();
                send_tick(tgt, meas, tick, 1'b0, '0, PH_STOP, pv);
                if (kind < 85)
                    trk_pos = sat32(longint'(trk_pos)
                                    + ((longint'(pv) * longint'(tick)) >>> FRACTION_BITS));
                if ($urandom_range(0, 49) == 0) settle();
                rand_ticks++;
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (pending_cmds.size() != 0) begin
            $display("%0d results never arrived", pending_cmds.size());
            mismatches += pending_cmds.size();
        end
        $display("Ran %0d ticks (%0d directed) with %0d register writes.", ticks_sent,
                 directed_ticks, reg_writes);
        $display("Phases seen: stop %0d, cruise %0d, accelerate %0d, decelerate %0d.",
                 phase_hits[PH_STOP], phase_hits[PH_CRUISE], phase_hits[PH_ACCEL],
                 phase_hits[PH_DECEL]);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
